// File: hdl/tce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the toy CPU execute unit
// Item layouts, operation and status codes, stack limits and the memory
// write request that travels from the execute logic to the data memory.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned ADDR_W = 16;

  localparam logic [7:0]  STACK_BASE  = 8'd16;
  localparam logic [7:0]  STACK_LIMIT = 8'd252;
  localparam logic [7:0]  WORD_BYTES  = 8'd4;
  localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;

  typedef enum logic [4:0] {
    OP_LDR_M = 5'd0,
    OP_LDR_I = 5'd1,
    OP_STR   = 5'd2,
    OP_ADD_M = 5'd3,
    OP_ADD_I = 5'd4,
    OP_SUB_M = 5'd5,
    OP_SUB_I = 5'd6,
    OP_JMP_M = 5'd7,
    OP_JMP_I = 5'd8,
    OP_JPZ_M = 5'd9,
    OP_JPZ_I = 5'd10,
    OP_RET   = 5'd11,
    OP_BRC_M = 5'd12,
    OP_BRC_I = 5'd13,
    OP_BRZ_M = 5'd14,
    OP_BRZ_I = 5'd15,
    OP_HLT   = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HALT  = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_ADDR  = 3'd4
  } status_e;

  typedef struct packed {
    logic [4:0]  operation;
    logic [2:0]  register_select;
    logic [31:0] body;
    logic [31:0] current_pc;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [31:0] register_value;
    logic        zero_flag;
    logic        negative_flag;
    logic        overflow_flag;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } wr_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] next_pc;
    logic        reg_we;
    logic [31:0] reg_wdata;
    logic        flag_we;
    logic        zero_n;
    logic        neg_n;
    logic        carry_n;
    logic        sp_we;
    logic [7:0]  sp_n;
    wr_t         wr;
  } exec_t;

endpackage
`default_nettype wire

// File: hdl/toy_cpu_execute_unit.sv
`default_nettype none
// An accepted item is registered in the execute stage, then its result in the result register.
// Throughput: one item per cycle; data memory is read at acceptance, so the
// execute stage has its words in the next cycle. A held result stalls input.
// Reset: synchronous; afterwards the data memory is zeroed at one row a cycle,
// while no item is taken.
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit: single-instruction execute unit
// Register file, flags, stack pointer and byte-banked data memory, with one
// execute stage and a result register.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit #(
  parameter int unsigned NUM_REGS  = 8,
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire tce_pkg::in_t  cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output tce_pkg::out_t      res
);
  import tce_pkg::*;

  localparam int unsigned RIDX = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [31:0]     regs [NUM_REGS];
  logic            zero_bit;
  logic            negative_bit;
  logic            carry_bit;
  logic [7:0]      sp;
  logic [7:0]      sp_next;
  logic            ex_valid;
  in_t             ex_item;
  logic            ex_fire;
  logic            accept;
  logic            clearing;
  logic            reg_in_range;
  logic [RIDX-1:0] ridx;
  logic [31:0]     reg_rd;
  logic [31:0]     mem_word;
  logic [31:0]     stack_word;
  exec_t           x;
  wr_t             wr;

  assign ex_fire   = ex_valid && (!res_valid || !res_stall);
  assign cmd_stall = clearing || (ex_valid && !ex_fire);
  assign accept    = cmd_valid && !cmd_stall;
  assign sp_next   = (ex_fire && x.sp_we) ? x.sp_n : sp;

  assign ridx         = RIDX'(ex_item.register_select);
  assign reg_in_range = 32'(ex_item.register_select) < NUM_REGS;
  assign reg_rd       = reg_in_range ? regs[ridx] : 32'd0;

  always_comb begin
    wr    = x.wr;
    wr.we = x.wr.we && ex_fire;
  end

  tce_dmem #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dmem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (cmd.body[ADDR_W-1:0]),
    .stk_addr (ADDR_W'(sp_next - WORD_BYTES)),
    .wr       (wr),
    .rd_word  (mem_word),
    .stk_word (stack_word),
    .clearing (clearing)
  );

  tce_exec #(
    .MEM_BYTES(MEM_BYTES)
  ) u_exec (
    .item       (ex_item),
    .reg_rd     (reg_rd),
    .zero       (zero_bit),
    .sp         (sp),
    .mem_word   (mem_word),
    .stack_word (stack_word),
    .x          (x)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid     <= 1'b0;
      res_valid    <= 1'b0;
      sp           <= STACK_BASE;
      zero_bit     <= 1'b0;
      negative_bit <= 1'b0;
      carry_bit    <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 32'd0;
      end
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (ex_fire) begin
        sp <= sp_next;
        if (x.flag_we) begin
          zero_bit     <= x.zero_n;
          negative_bit <= x.neg_n;
          carry_bit    <= x.carry_n;
        end
        if (x.reg_we && reg_in_range) begin
          regs[ridx] <= x.reg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      res.status         <= x.status;
      res.next_pc        <= x.next_pc;
      res.register_value <= !reg_in_range ? 32'd0 : (x.reg_we ? x.reg_wdata : reg_rd);
      res.zero_flag      <= x.flag_we ? x.zero_n : zero_bit;
      res.negative_flag  <= x.flag_we ? x.neg_n : negative_bit;
      res.overflow_flag  <= x.flag_we ? x.carry_n : carry_bit;
    end
  end

  // The stack pointer stays word aligned inside the stack area.
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp[1:0] == 2'd0 && sp >= STACK_BASE && sp <= STACK_LIMIT)
    else $error("stack pointer left the stack area");

  // Nothing is written to data memory while it is being cleared.
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr.we)
    else $error("memory write during clearing pass");

  // An executed item always shows up in the result register.
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    ex_fire |=> res_valid)
    else $error("executed item produced no result");

  // A fault or halt leaves all state unchanged.
  a_fault_no_update: assert property (@(posedge clk) disable iff (rst)
    ex_fire && x.status != ST_OK |-> !x.reg_we && !x.wr.we && !x.sp_we && !x.flag_we)
    else $error("state update on fault or halt");

endmodule
`default_nettype wire

// File: hdl/tce_dmem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_dmem: byte-banked data memory
// Four byte banks give one unaligned 32-bit word read, one aligned stack word
// read and one unaligned word write per cycle. Read data is registered and
// merged with the write that happened at the same edge. A clearing pass
// zeroes every row after reset.
// ----------------------------------------------------------------------------
module tce_dmem #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [tce_pkg::ADDR_W-1:0] rd_addr,
  input  wire logic [tce_pkg::ADDR_W-1:0] stk_addr,
  input  wire tce_pkg::wr_t               wr,
  output logic [31:0]                     rd_word,
  output logic [31:0]                     stk_word,
  output logic                            clearing
);
  import tce_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = 2 ** RW;

  logic [AW-1:0] ra;
  logic [AW-1:0] sa;
  logic [AW-1:0] wa;
  logic [1:0]    ra_lo;
  logic [RW-1:0] clr_row;
  logic [7:0]    byte_a [4];
  logic [7:0]    byte_b [4];

  assign ra = rd_addr[AW-1:0];
  assign sa = stk_addr[AW-1:0];
  assign wa = wr.addr[AW-1:0];

  // Row of bank b that holds one of the four bytes of the word at address a.
  function automatic logic [RW-1:0] bank_row(input logic [AW-1:0] a, input logic [1:0] b);
    logic [1:0]    k;
    logic [AW-1:0] s;
    k = b - a[1:0];
    s = a + AW'(k);
    return s[AW-1:2];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_lo <= ra[1:0];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [RW-1:0] rrow_a;
    logic [RW-1:0] rrow_b;
    logic [RW-1:0] wrow;
    logic [1:0]    wk;
    logic [31:0]   wsh;
    logic [7:0]    wbyte;
    logic [7:0]    rdata_a;
    logic [7:0]    rdata_b;
    logic [RW-1:0] rrow_a_q;
    logic [RW-1:0] rrow_b_q;
    logic          fwd_en;
    logic [RW-1:0] fwd_row;
    logic [7:0]    fwd_byte;

    assign rrow_a = bank_row(ra, 2'(g));
    assign rrow_b = bank_row(sa, 2'(g));
    assign wrow   = bank_row(wa, 2'(g));
    assign wk     = 2'(g) - wa[1:0];
    assign wsh    = wr.data >> {wk, 3'b000};
    assign wbyte  = wsh[7:0];

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_row] <= 8'd0;
      end else if (wr.we) begin
        mem[wrow] <= wbyte;
      end
      if (rd_en) begin
        rdata_a  <= mem[rrow_a];
        rdata_b  <= mem[rrow_b];
        rrow_a_q <= rrow_a;
        rrow_b_q <= rrow_b;
        fwd_row  <= wrow;
        fwd_byte <= wbyte;
      end
    end

    // The write landing at the read edge is not yet in the read data.
    always_ff @(posedge clk) begin
      if (rst) begin
        fwd_en <= 1'b0;
      end else if (rd_en) begin
        fwd_en <= wr.we && !clearing;
      end
    end

    assign byte_a[g] = (fwd_en && fwd_row == rrow_a_q) ? fwd_byte : rdata_a;
    assign byte_b[g] = (fwd_en && fwd_row == rrow_b_q) ? fwd_byte : rdata_b;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_word[8*k +: 8]  = byte_a[2'(ra_lo + 2'(k))];
      stk_word[8*k +: 8] = byte_b[k];
    end
  end

endmodule
`default_nettype wire

// File: hdl/tce_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_exec: instruction decode and execute
// Works out status, next program counter, register, flag, stack pointer and
// memory updates for one instruction from the current state and the words
// read from data memory.
// ----------------------------------------------------------------------------
module tce_exec #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  wire tce_pkg::in_t  item,
  input  wire logic [31:0]   reg_rd,
  input  wire logic          zero,
  input  wire logic [7:0]    sp,
  input  wire logic [31:0]   mem_word,
  input  wire logic [31:0]   stack_word,
  output tce_pkg::exec_t     x
);
  import tce_pkg::*;

  logic        from_mem;
  logic        addr_ok;
  logic [31:0] operand;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [7:0]  sp_dec;

  assign from_mem = item.operation == OP_LDR_M || item.operation == OP_ADD_M
                 || item.operation == OP_SUB_M || item.operation == OP_JMP_M
                 || item.operation == OP_JPZ_M || item.operation == OP_BRC_M
                 || item.operation == OP_BRZ_M;
  assign addr_ok  = item.body <= 32'(MEM_BYTES - 4);
  assign operand  = from_mem ? mem_word : item.body;
  assign sum      = {1'b0, reg_rd} + {1'b0, operand};
  assign diff     = {1'b0, reg_rd} - {1'b0, operand};
  assign sp_dec   = sp - WORD_BYTES;

  always_comb begin
    x           = '0;
    x.status    = ST_OK;
    x.next_pc   = item.current_pc;
    x.reg_wdata = operand;
    x.sp_n      = sp;
    x.wr.addr   = item.body[ADDR_W-1:0];
    x.wr.data   = reg_rd;
    unique case (item.operation)
      OP_LDR_M, OP_LDR_I, OP_ADD_M, OP_ADD_I, OP_SUB_M, OP_SUB_I, OP_BRC_M,
      OP_BRC_I: begin
        if (from_mem && !addr_ok) begin
          x.status = ST_ADDR;
        end else if (item.operation == OP_LDR_M || item.operation == OP_LDR_I) begin
          x.reg_we = 1'b1;
        end else if (item.operation == OP_ADD_M || item.operation == OP_ADD_I) begin
          x.reg_we    = 1'b1;
          x.reg_wdata = sum[31:0];
          x.flag_we   = 1'b1;
          x.carry_n   = sum[32];
        end else if (item.operation == OP_SUB_M || item.operation == OP_SUB_I) begin
          x.reg_we    = 1'b1;
          x.reg_wdata = diff[31:0];
          x.flag_we   = 1'b1;
          x.carry_n   = diff[32];
        end else begin
          x.next_pc = operand;
        end
      end
      OP_STR: begin
        if (!addr_ok) begin
          x.status = ST_ADDR;
        end else begin
          x.wr.we = 1'b1;
        end
      end
      OP_JMP_M, OP_JMP_I, OP_JPZ_M, OP_JPZ_I: begin
        if ((item.operation == OP_JPZ_M || item.operation == OP_JPZ_I) && !zero) begin
          x.status = ST_OK;
        end else if (sp >= STACK_LIMIT) begin
          x.status = ST_FULL;
        end else if (from_mem && !addr_ok) begin
          x.status = ST_ADDR;
        end else begin
          x.wr.we   = 1'b1;
          x.wr.addr = ADDR_W'(sp);
          x.wr.data = item.current_pc;
          x.sp_we   = 1'b1;
          x.sp_n    = sp + WORD_BYTES;
          x.next_pc = operand;
        end
      end
      OP_RET: begin
        if (sp <= STACK_BASE) begin
          x.status = ST_EMPTY;
        end else begin
          // The popped word is cleared as it is read.
          x.sp_we   = 1'b1;
          x.sp_n    = sp_dec;
          x.next_pc = stack_word;
          x.wr.we   = 1'b1;
          x.wr.addr = ADDR_W'(sp_dec);
          x.wr.data = 32'd0;
        end
      end
      OP_BRZ_M, OP_BRZ_I: begin
        if (!zero) begin
          x.status = ST_OK;
        end else if (from_mem && !addr_ok) begin
          x.status = ST_ADDR;
        end else begin
          x.next_pc = operand;
        end
      end
      default: begin
        x.status = ST_HALT;
      end
    endcase
    x.zero_n = x.reg_wdata == 32'd0;
    x.neg_n  = (x.reg_wdata & SIGN_MASK) != 32'd0;
  end

endmodule
`default_nettype wire
